FILE: hw/rtl/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

  // Fixed field widths of the request and result words
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned FILE_W  = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned LINE_W  = 24;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_OPEN     = 3'd0,
    REQ_CLOSE    = 3'd1,
    REQ_SET_LINE = 3'd2,
    REQ_READ     = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_SET_LINE,
    CELL_CLEAR
  } cell_op_e;

  // Update command broadcast to every cell
  typedef struct packed {
    logic     apply;
    cell_op_e op;
    logic     hit;    // picked entry already holds the file id
    logic     shift;  // picked entry was open: close the gap in the rank order
  } cell_cmd_t;

  // Per-cell status seen by the decision logic
  typedef struct packed {
    logic valid;
    logic match;   // open and holds the requested file id
    logic pinned;  // holds the keep id while keep is in force
  } cell_stat_t;

endpackage

FILE: hw/rtl/lst_cell.sv
`timescale 1ns / 1ps

module lst_cell
  import lst_pkg::*;
#(
  parameter int unsigned RankW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic              pick_i,
  input  logic [RankW-1:0]  pivot_rank_i,
  input  logic [RankW-1:0]  new_rank_i,
  input  logic [FILE_W-1:0] fid_i,
  input  logic [FILE_W-1:0] kid_i,
  input  logic              keep_on_i,
  input  logic [LINE_W-1:0] line_i,
  input  logic              free_seen_i,
  output logic              free_seen_o,
  output logic              pick_free_o,
  output cell_stat_t        stat_o,
  output logic [RankW-1:0]  rank_o,
  output logic [FILE_W-1:0] file_o,
  output logic [LINE_W-1:0] line_o
);

  logic              valid_q;
  logic [FILE_W-1:0] file_q;
  logic [LINE_W-1:0] line_q;
  logic [RankW-1:0]  rank_q;
  logic              older;

  // first-free search ripples from the low-index neighbour
  assign pick_free_o   = !valid_q && !free_seen_i;
  assign free_seen_o   = free_seen_i || !valid_q;
  assign stat_o.valid  = valid_q;
  assign stat_o.match  = valid_q && (file_q == fid_i);
  assign stat_o.pinned = keep_on_i && (file_q == kid_i);
  assign rank_o        = rank_q;
  assign file_o        = file_q;
  assign line_o        = line_q;

  assign older = cmd_i.shift && valid_q && (rank_q > pivot_rank_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      file_q  <= '0;
      line_q  <= '0;
      rank_q  <= '0;
    end else if (cmd_i.apply) begin
      case (cmd_i.op)
        CELL_CLEAR: begin
          valid_q <= 1'b0;
          file_q  <= '0;
          line_q  <= '0;
          rank_q  <= '0;
        end
        CELL_OPEN: begin
          if (pick_i) begin
            valid_q <= 1'b1;
            rank_q  <= new_rank_i;
            if (!cmd_i.hit) begin
              file_q <= fid_i;
              line_q <= '0;
            end
          end else if (older) begin
            rank_q <= rank_q - RankW'(1);
          end
        end
        CELL_CLOSE: begin
          if (pick_i) begin
            valid_q <= 1'b0;
            file_q  <= '0;
            line_q  <= '0;
            rank_q  <= '0;
          end else if (older) begin
            rank_q <= rank_q - RankW'(1);
          end
        end
        CELL_SET_LINE: begin
          if (pick_i) begin
            line_q <= line_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/lru_slot_table_with_pinned_entry_unit.sv
`timescale 1ns / 1ps

// Fully associative slot table with LRU replacement and one pinned file id.
// Input channel: in_valid_i / in_stall_o carries one request word (open,
// close, set line, read, clear). Output channel: out_valid_o / out_stall_i
// carries one result word per request, always with the open count after it.
// The table is a row of SLOTS cells; each keeps valid, file id, line and a
// recency rank. A free-slot search ripples cell to cell along the row.
// The request word, then the decision, then the result are each registered.
// A request passes a decide step and an update step over the cell row; the
// row is read in the decide step and written in the update step.
// A new request is taken in the update step of the last one, provided the
// output register is free.
// When the receiver stalls, the result waits in the output register; the
// next request is decided but its update is held until that word is taken.
// Reset (asynchronous, active low) empties every entry, clears the open
// count and drops any pending word.
module lru_slot_table_with_pinned_entry_unit
  import lst_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [FILE_W-1:0]  file_id_i,
  input  logic               file_id_valid_i,
  input  logic [FILE_W-1:0]  keep_id_i,
  input  logic               keep_valid_i,
  input  logic [SLOT_W-1:0]  slot_sel_i,
  input  logic [LINE_W-1:0]  line_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SLOT_W-1:0]  slot_out_o,
  output logic               slot_ok_o,
  output logic [FILE_W-1:0]  file_id_out_o,
  output logic               file_present_o,
  output logic [LINE_W-1:0]  line_out_o,
  output logic [COUNT_W-1:0] open_count_o
);

  localparam int unsigned IdxW  = $clog2(SLOTS);
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_APPLY
  } state_e;

  state_e state_q;

  // captured request word
  logic [REQ_W-1:0]  req_q;
  logic [FILE_W-1:0] fid_q;
  logic              fid_ok_q;
  logic [FILE_W-1:0] kid_q;
  logic              keep_on_q;
  logic [SLOT_W-1:0] sel_q;
  logic [LINE_W-1:0] lv_q;

  // decision registers
  logic [SLOTS-1:0]  pick_q;
  cell_op_e          op_q;
  logic              hit_q;
  logic              shift_q;
  logic [RankW-1:0]  pivot_q;
  logic [RankW-1:0]  new_rank_q;
  logic [IdxW-1:0]   idx_q;
  logic              ok_q;
  logic [FILE_W-1:0] rd_file_q;
  logic              rd_present_q;
  logic [LINE_W-1:0] rd_line_q;
  logic [CntW-1:0]   cnt_next_q;
  logic [CntW-1:0]   count_q;

  // output register
  logic               out_valid_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               slot_ok_q;
  logic [FILE_W-1:0]  file_out_q;
  logic               present_q;
  logic [LINE_W-1:0]  line_out_q;
  logic [COUNT_W-1:0] open_count_q;

  // cell row
  cell_stat_t        stat   [SLOTS];
  logic [RankW-1:0]  rank_a [SLOTS];
  logic [FILE_W-1:0] file_a [SLOTS];
  logic [LINE_W-1:0] line_a [SLOTS];
  logic [SLOTS:0]    free_seen;
  logic [SLOTS-1:0]  free_first;
  cell_cmd_t         cmd;

  logic              out_free;
  logic              fire;
  logic              in_acc;

  // decision logic
  logic [SLOTS-1:0]  match_v;
  logic [SLOTS-1:0]  vict0_v;
  logic [SLOTS-1:0]  vict1_v;
  logic [SLOTS-1:0]  sel_v;
  logic [SLOTS-1:0]  pick_d;
  cell_op_e          op_d;
  logic              hit_d;
  logic              shift_d;
  logic [RankW-1:0]  pivot_d;
  logic [RankW-1:0]  new_rank_d;
  logic [IdxW-1:0]   idx_d;
  logic              ok_d;
  logic [FILE_W-1:0] rd_file_d;
  logic              rd_present_d;
  logic [LINE_W-1:0] rd_line_d;
  logic [CntW-1:0]   cnt_next_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = (state_q == ST_APPLY) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || fire);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cmd.apply = fire;
  assign cmd.op    = op_q;
  assign cmd.hit   = hit_q;
  assign cmd.shift = shift_q;

  assign free_seen[0] = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lst_cell #(
      .RankW (RankW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .pick_i       (pick_q[g]),
      .pivot_rank_i (pivot_q),
      .new_rank_i   (new_rank_q),
      .fid_i        (fid_q),
      .kid_i        (kid_q),
      .keep_on_i    (keep_on_q),
      .line_i       (lv_q),
      .free_seen_i  (free_seen[g]),
      .free_seen_o  (free_seen[g+1]),
      .pick_free_o  (free_first[g]),
      .stat_o       (stat[g]),
      .rank_o       (rank_a[g]),
      .file_o       (file_a[g]),
      .line_o       (line_a[g])
    );
  end

  // Per-cell flags: hit, LRU victim (rank 0, else rank 1 when rank 0 is
  // pinned) and selector decode; ids are unique so at most one cell pins.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_v[i] = stat[i].match;
      vict0_v[i] = stat[i].valid && !stat[i].pinned && (rank_a[i] == '0);
      vict1_v[i] = stat[i].valid && !stat[i].pinned && (rank_a[i] == RankW'(1));
      sel_v[i]   = stat[i].valid && (sel_q == SLOT_W'(i));
    end
  end

  always_comb begin
    pick_d       = '0;
    op_d         = CELL_NONE;
    hit_d        = 1'b0;
    shift_d      = 1'b0;
    ok_d         = 1'b0;
    cnt_next_d   = count_q;
    case (req_q)
      REQ_OPEN: begin
        if (fid_ok_q) begin
          if (|match_v) begin
            pick_d  = match_v;
            hit_d   = 1'b1;
            shift_d = 1'b1;
          end else if (free_seen[SLOTS]) begin
            pick_d = free_first;
          end else begin
            pick_d  = (|vict0_v) ? vict0_v : vict1_v;
            shift_d = 1'b1;
          end
          ok_d = |pick_d;
          if (ok_d) begin
            op_d = CELL_OPEN;
          end
          if (ok_d && !shift_d) begin
            cnt_next_d = count_q + CntW'(1);
          end
        end
      end
      REQ_CLOSE: begin
        // only close the rank gap when an open entry is actually dropped
        pick_d  = sel_v;
        shift_d = |sel_v;
        op_d    = CELL_CLOSE;
        if (|sel_v) begin
          cnt_next_d = count_q - CntW'(1);
        end
      end
      REQ_SET_LINE: begin
        pick_d = sel_v;
        op_d   = CELL_SET_LINE;
      end
      REQ_CLEAR: begin
        op_d       = CELL_CLEAR;
        cnt_next_d = '0;
      end
      default: begin
      end
    endcase
  end

  // one-hot pick and selector to index, rank and read data
  always_comb begin
    pivot_d      = '0;
    idx_d        = '0;
    rd_file_d    = '0;
    rd_line_d    = '0;
    rd_present_d = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick_d[i]) begin
        pivot_d = pivot_d | rank_a[i];
        idx_d   = idx_d | IdxW'(i);
      end
      if (sel_v[i] && (req_q == REQ_READ)) begin
        rd_file_d    = rd_file_d | file_a[i];
        rd_line_d    = rd_line_d | line_a[i];
        rd_present_d = 1'b1;
      end
    end
  end

  // an entry already open ranks among the others, so it lands one lower
  assign new_rank_d = shift_d ? RankW'(count_q - CntW'(1)) : RankW'(count_q);

  // capture the request word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_type_i;
      fid_q     <= file_id_i;
      fid_ok_q  <= file_id_valid_i;
      kid_q     <= keep_id_i;
      keep_on_q <= keep_valid_i;
      sel_q     <= slot_sel_i;
      lv_q      <= line_value_i;
    end
  end

  // hold the decision for the update cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      pick_q       <= pick_d;
      hit_q        <= hit_d;
      shift_q      <= shift_d;
      pivot_q      <= pivot_d;
      new_rank_q   <= new_rank_d;
      idx_q        <= idx_d;
      ok_q         <= ok_d;
      rd_file_q    <= rd_file_d;
      rd_present_q <= rd_present_d;
      rd_line_q    <= rd_line_d;
      cnt_next_q   <= cnt_next_d;
    end
  end

  // sequencer, open count, cell op and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= CELL_NONE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new word, else drop the one just taken
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          op_q    <= op_d;
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (fire) begin
            count_q <= cnt_next_q;
            state_q <= in_acc ? ST_DECIDE : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slot_q       <= ok_q ? SLOT_W'(idx_q) : '0;
      slot_ok_q    <= ok_q;
      file_out_q   <= rd_file_q;
      present_q    <= rd_present_q;
      line_out_q   <= rd_line_q;
      open_count_q <= COUNT_W'(cnt_next_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_out_o     = slot_q;
  assign slot_ok_o      = slot_ok_q;
  assign file_id_out_o  = file_out_q;
  assign file_present_o = present_q;
  assign line_out_o     = line_out_q;
  assign open_count_o   = open_count_q;

endmodule
